// ----- rtl/peer_capability_payload_parser_macros.svh -----
// Assertion macros for the peer capability payload parser.
// Used by the top level only; the macros expect i_clk and i_rst_n in scope.
`ifndef PEER_CAPABILITY_PAYLOAD_PARSER_MACROS_SVH
`define PEER_CAPABILITY_PAYLOAD_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define PCPP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PCPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCPP_ASSERT_SAME(lbl, ante, cons, msg)
`define PCPP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/pcpp_pkg.sv -----
// Shared types and constants of the peer capability payload parser.
// No dependencies; all other design files but the RAM and the macros header refer to it by scoped names.
package pcpp_pkg;

    localparam int MAX_VERSIONS = 8;
    localparam int QUEUE_DEPTH  = 2;
    // Wide enough for a stored count over the whole parameter range.
    localparam int JOB_CNT_W    = 7;

    localparam logic OP_PAYLOAD  = 1'b0;
    localparam logic OP_SALT     = 1'b1;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_SALT   = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_MALFORMED   = 2'd1;
    localparam logic [1:0] ST_NO_VERSIONS = 2'd2;

    // One job handed from the parser to the output sequencer.
    typedef struct packed {
        logic                 kind;
        logic [1:0]           status;
        logic [15:0]          channel;
        logic [7:0]           feature;
        logic [JOB_CNT_W-1:0] count;
        logic [15:0]          sel;
    } t_job;

    typedef struct packed {
        logic salt_active;
        logic salt_done;
    } t_back_status;

endpackage

// ----- rtl/peer_capability_payload_parser.sv -----
// Top level of the peer capability payload parser: front end, job queue,
// version store and back end. Depends on pcpp_pkg and the macros header.
//
//  channel  dir  tdata                            tuser        tlast
//  s_axis   in   data_byte, selected_version      operation    end_of_payload
//  m_axis   out  status, channel_number,          result_kind  last_result
//                feature_bits, version_count, salt_byte
//
// A payload's report passes through the job queue and then the output register.
// A salt request with n > 0 stored versions produces 2n+2 bytes, one per cycle
// while the sink is ready; the versions come through the back end's single store
// read port. Input is held off from the salt request until its last byte is
// loaded. Reset is synchronous and needs no clearing pass; sink stalls fill the
// output register and then the queue before input stalls.
`include "peer_capability_payload_parser_macros.svh"

module peer_capability_payload_parser #(
    parameter int MAX_VERSIONS = pcpp_pkg::MAX_VERSIONS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] data_byte, [23:8] selected_version
    input  logic [23:0] i_s_tdata,
    // [0] operation
    input  logic        i_s_tuser,
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [1:0] status, [17:2] channel_number, [25:18] feature_bits,
    // [29:26] version_count, [37:30] salt_byte, [39:38] zero
    output logic [39:0] o_m_tdata,
    // [0] result_kind
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    localparam int IDX_W = (MAX_VERSIONS > 1) ? $clog2(MAX_VERSIONS) : 1;

    pcpp_pkg::t_job         push_job, head_job;
    pcpp_pkg::t_back_status back_st;
    logic                   q_push, q_full, q_pop, q_valid;
    logic                   ram_we, ram_re;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    logic [15:0]            ram_wdata, ram_rdata;
    logic [1:0]             res_status;
    logic [15:0]            res_chan;
    logic [7:0]             res_feat, res_salt;
    logic [3:0]             res_cnt;

    pcpp_front #(.MAX_VERSIONS(MAX_VERSIONS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_op    (i_s_tuser),
        .i_byte  (i_s_tdata[7:0]),
        .i_eop   (i_s_tlast),
        .i_sel   (i_s_tdata[23:8]),
        .o_push  (q_push),
        .o_job   (push_job),
        .i_full  (q_full),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_wdata (ram_wdata),
        .i_back  (back_st)
    );

    pcpp_queue #(.DEPTH(pcpp_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    pcpp_ram #(.WIDTH(16), .DEPTH(MAX_VERSIONS)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pcpp_back #(.MAX_VERSIONS(MAX_VERSIONS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (head_job),
        .o_pop        (q_pop),
        .o_re         (ram_re),
        .o_raddr      (ram_raddr),
        .i_rdata      (ram_rdata),
        .o_status     (back_st),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_kind       (o_m_tuser),
        .o_res_status (res_status),
        .o_channel    (res_chan),
        .o_feature    (res_feat),
        .o_count      (res_cnt),
        .o_salt       (res_salt),
        .o_last       (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, res_salt, res_cnt, res_feat, res_chan, res_status};

    `PCPP_ASSERT_SAME(a_no_push_when_full, q_push, !q_full, "job pushed into a full queue")
    `PCPP_ASSERT_SAME(a_store_quiet_in_salt, ram_we, !back_st.salt_active,
        "version store written while a salt is streamed")
    `PCPP_ASSERT_NEXT(a_salt_end_marked, back_st.salt_done, o_m_tvalid && o_m_tlast,
        "salt finished without a last byte on the output")

endmodule

// ----- rtl/pcpp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcpp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pcpp_queue.sv -----
// Short job queue between the parser and the output sequencer.
// Depends on pcpp_pkg for the job type.
module pcpp_queue #(
    parameter int DEPTH = pcpp_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pcpp_pkg::t_job    i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output pcpp_pkg::t_job    o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pcpp_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

endmodule

// ----- rtl/pcpp_front.sv -----
// Front end: accepts input beats, walks the payload grammar, writes versions
// to the store and queues parse reports and salt jobs. Depends on pcpp_pkg.
module pcpp_front #(
    parameter int MAX_VERSIONS = pcpp_pkg::MAX_VERSIONS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [7:0]                    i_byte,
    input  logic                          i_eop,
    input  logic [15:0]                   i_sel,
    output logic                          o_push,
    output pcpp_pkg::t_job                o_job,
    input  logic                          i_full,
    output logic                          o_we,
    output logic [(MAX_VERSIONS > 1 ? $clog2(MAX_VERSIONS) : 1)-1:0] o_waddr,
    output logic [15:0]                   o_wdata,
    input  pcpp_pkg::t_back_status        i_back
);

    localparam int IDX_W = (MAX_VERSIONS > 1) ? $clog2(MAX_VERSIONS) : 1;
    localparam int CNT_W = $clog2(MAX_VERSIONS + 1);
    localparam int JCW   = pcpp_pkg::JOB_CNT_W;

    typedef enum logic [5:0] {
        P_HEADER   = 6'b000001,
        P_LIST_LEN = 6'b000010,
        P_VERSIONS = 6'b000100,
        P_FEAT_LEN = 6'b001000,
        P_FEATURES = 6'b010000,
        P_DONE     = 6'b100000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_idx, n_idx;
    logic [15:0] r_hdr, n_hdr;
    logic [7:0] r_list, n_list;
    logic [7:0] r_flen, n_flen;
    logic [7:0] r_fval, n_fval;
    logic       r_err, n_err;
    logic [7:0] r_hi, n_hi;
    logic [CNT_W-1:0] r_stored, n_stored;
    logic       r_busy, n_busy;

    logic       accept;
    logic       ok;
    logic [8:0] idx_inc;

    // A salt job holds off all input until its last byte has been handed over,
    // so the version store cannot change under it.
    assign o_ready = !i_full && !r_busy;
    assign accept  = i_valid && o_ready;
    assign idx_inc = {1'b0, r_idx} + 9'd1;

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_hdr    = r_hdr;
        n_list   = r_list;
        n_flen   = r_flen;
        n_fval   = r_fval;
        n_err    = r_err;
        n_hi     = r_hi;
        n_stored = r_stored;
        n_busy   = r_busy;
        o_push   = 1'b0;
        o_job    = '0;
        o_we     = 1'b0;
        o_waddr  = r_idx[IDX_W:1];
        o_wdata  = {r_hi, i_byte};
        ok       = 1'b0;

        if (i_back.salt_done) begin
            n_busy = 1'b0;
        end

        if (accept && i_op == pcpp_pkg::OP_PAYLOAD) begin
            if (r_phase == P_HEADER && r_idx == 8'd0) begin
                n_stored = '0;
            end
            if (!r_err) begin
                case (r_phase)
                    P_HEADER: begin
                        if (r_idx == 8'd0) begin
                            n_hdr = {8'h00, i_byte};
                            n_idx = 8'd1;
                        end else begin
                            n_hdr   = {r_hdr[7:0], i_byte};
                            n_idx   = 8'd0;
                            n_phase = P_LIST_LEN;
                        end
                    end
                    P_LIST_LEN: begin
                        n_list = i_byte;
                        if (i_byte[0] || ({1'b0, i_byte} > 9'(2 * MAX_VERSIONS))) begin
                            n_err = 1'b1;
                        end else begin
                            n_idx   = 8'd0;
                            n_phase = (i_byte == 8'd0) ? P_FEAT_LEN : P_VERSIONS;
                        end
                    end
                    P_VERSIONS: begin
                        // The high byte waits here; the word is written whole.
                        if (!r_idx[0]) begin
                            n_hi = i_byte;
                        end else begin
                            o_we = 1'b1;
                        end
                        if (idx_inc >= {1'b0, r_list}) begin
                            n_idx   = 8'd0;
                            n_phase = P_FEAT_LEN;
                        end else begin
                            n_idx = idx_inc[7:0];
                        end
                    end
                    P_FEAT_LEN: begin
                        n_flen = i_byte;
                        if (i_byte == 8'd0) begin
                            n_err = 1'b1;
                        end else begin
                            n_idx   = 8'd0;
                            n_phase = P_FEATURES;
                        end
                    end
                    P_FEATURES: begin
                        if (r_idx == 8'd0) begin
                            n_fval = i_byte;
                        end
                        n_idx = idx_inc[7:0];
                        if (idx_inc >= {1'b0, r_flen}) begin
                            n_phase = P_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_eop) begin
                ok       = !n_err && (n_phase == P_DONE);
                n_stored = ok ? CNT_W'(n_list >> 1) : '0;
                o_push   = 1'b1;
                o_job.kind = pcpp_pkg::KIND_REPORT;
                if (ok) begin
                    o_job.status  = pcpp_pkg::ST_OK;
                    o_job.channel = n_hdr;
                    o_job.feature = n_fval;
                    o_job.count   = JCW'(n_stored);
                end else begin
                    o_job.status  = pcpp_pkg::ST_MALFORMED;
                end
                n_phase = P_HEADER;
                n_idx   = 8'd0;
                n_err   = 1'b0;
            end
        end else if (accept) begin
            o_push       = 1'b1;
            o_job.kind   = pcpp_pkg::KIND_SALT;
            o_job.status = (r_stored == '0) ? pcpp_pkg::ST_NO_VERSIONS : pcpp_pkg::ST_OK;
            o_job.count  = JCW'(r_stored);
            o_job.sel    = i_sel;
            n_busy       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= P_HEADER;
            r_idx    <= '0;
            r_hdr    <= '0;
            r_list   <= '0;
            r_flen   <= '0;
            r_fval   <= '0;
            r_err    <= 1'b0;
            r_stored <= '0;
            r_busy   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_hdr    <= n_hdr;
            r_list   <= n_list;
            r_flen   <= n_flen;
            r_fval   <= n_fval;
            r_err    <= n_err;
            r_stored <= n_stored;
            r_busy   <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
    end

endmodule

// ----- rtl/pcpp_back.sv -----
// Back end: takes jobs from the queue, reads the version store and drives the
// output register with reports and salt bytes. Depends on pcpp_pkg.
module pcpp_back #(
    parameter int MAX_VERSIONS = pcpp_pkg::MAX_VERSIONS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  pcpp_pkg::t_job                i_job,
    output logic                          o_pop,
    output logic                          o_re,
    output logic [(MAX_VERSIONS > 1 ? $clog2(MAX_VERSIONS) : 1)-1:0] o_raddr,
    input  logic [15:0]                   i_rdata,
    output pcpp_pkg::t_back_status        o_status,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_kind,
    output logic [1:0]                    o_res_status,
    output logic [15:0]                   o_channel,
    output logic [7:0]                    o_feature,
    output logic [3:0]                    o_count,
    output logic [7:0]                    o_salt,
    output logic                          o_last
);

    localparam int IDX_W = (MAX_VERSIONS > 1) ? $clog2(MAX_VERSIONS) : 1;
    localparam int CNT_W = $clog2(MAX_VERSIONS + 1);

    typedef enum logic [4:0] {
        B_IDLE   = 5'b00001,
        B_HI     = 5'b00010,
        B_LO     = 5'b00100,
        B_SEL_HI = 5'b01000,
        B_SEL_LO = 5'b10000
    } t_bstate;

    t_bstate          r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_n, n_n;
    logic [15:0]      r_sel, n_sel;
    logic [3:0]       r_cnt4, n_cnt4;

    logic        r_valid, n_valid;
    logic        r_kind, n_kind;
    logic [1:0]  r_st, n_st;
    logic [15:0] r_chan, n_chan;
    logic [7:0]  r_feat, n_feat;
    logic [3:0]  r_ocnt, n_ocnt;
    logic [7:0]  r_salt, n_salt;
    logic        r_last, n_last;

    logic out_free;
    logic more;
    logic done;

    assign out_free = !r_valid || i_ready;
    assign more     = ((CNT_W + 1)'(r_idx) + (CNT_W + 1)'(1)) < {1'b0, r_n};

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_n     = r_n;
        n_sel   = r_sel;
        n_cnt4  = r_cnt4;
        n_valid = r_valid && !i_ready;
        n_kind  = r_kind;
        n_st    = r_st;
        n_chan  = r_chan;
        n_feat  = r_feat;
        n_ocnt  = r_ocnt;
        n_salt  = r_salt;
        n_last  = r_last;
        o_pop   = 1'b0;
        o_re    = 1'b0;
        o_raddr = r_idx;
        done    = 1'b0;

        case (r_state)
            B_IDLE: begin
                if (i_job_valid && out_free) begin
                    o_pop = 1'b1;
                    if (i_job.kind == pcpp_pkg::KIND_REPORT ||
                        i_job.status == pcpp_pkg::ST_NO_VERSIONS) begin
                        n_valid = 1'b1;
                        n_kind  = i_job.kind;
                        n_st    = i_job.status;
                        n_chan  = i_job.channel;
                        n_feat  = i_job.feature;
                        n_ocnt  = i_job.count[3:0];
                        n_salt  = 8'd0;
                        n_last  = 1'b1;
                        done    = (i_job.kind == pcpp_pkg::KIND_SALT);
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = '0;
                        n_idx   = '0;
                        n_n     = CNT_W'(i_job.count);
                        n_sel   = i_job.sel;
                        n_cnt4  = i_job.count[3:0];
                        n_state = B_HI;
                    end
                end
            end
            B_HI, B_LO, B_SEL_HI, B_SEL_LO: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    n_kind  = pcpp_pkg::KIND_SALT;
                    n_st    = pcpp_pkg::ST_OK;
                    n_chan  = 16'd0;
                    n_feat  = 8'd0;
                    n_ocnt  = r_cnt4;
                    n_last  = 1'b0;
                    case (r_state)
                        B_HI: begin
                            n_salt  = i_rdata[15:8];
                            n_state = B_LO;
                        end
                        B_LO: begin
                            n_salt = i_rdata[7:0];
                            if (more) begin
                                // Fetch the next version while this version's low byte is sent.
                                o_re    = 1'b1;
                                o_raddr = r_idx + IDX_W'(1);
                                n_idx   = r_idx + IDX_W'(1);
                                n_state = B_HI;
                            end else begin
                                n_state = B_SEL_HI;
                            end
                        end
                        B_SEL_HI: begin
                            n_salt  = r_sel[15:8];
                            n_state = B_SEL_LO;
                        end
                        default: begin
                            n_salt  = r_sel[7:0];
                            n_last  = 1'b1;
                            done    = 1'b1;
                            n_state = B_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_n    <= n_n;
        r_sel  <= n_sel;
        r_cnt4 <= n_cnt4;
        r_kind <= n_kind;
        r_st   <= n_st;
        r_chan <= n_chan;
        r_feat <= n_feat;
        r_ocnt <= n_ocnt;
        r_salt <= n_salt;
        r_last <= n_last;
    end

    assign o_status.salt_active = (r_state != B_IDLE);
    assign o_status.salt_done   = done;

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_res_status = r_st;
    assign o_channel    = r_chan;
    assign o_feature    = r_feat;
    assign o_count      = r_ocnt;
    assign o_salt       = r_salt;
    assign o_last       = r_last;

endmodule

// ----- test/peer_capability_payload_parser_tb.sv -----
// Self-checking testbench for peer_capability_payload_parser: directed and random
// capability payloads and salt requests, checked beat by beat against a built-in predictor.
// Depends on pcpp_pkg and the parser RTL only.
`timescale 1ns / 100ps

module peer_capability_payload_parser_tb;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int VT_IDX_W = (pcpp_pkg::MAX_VERSIONS > 1) ? $clog2(pcpp_pkg::MAX_VERSIONS) : 1;

    typedef enum logic [2:0] {
        SEG_CHANNEL, SEG_LIST_LEN, SEG_VERSIONS, SEG_FEAT_LEN, SEG_FEATURES, SEG_DONE
    } t_payload_seg;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [15:0] channel;
        logic [7:0] feature;
        logic [3:0] count;
        logic [7:0] salt;
        logic       last;
    } t_result_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int beats_sent = 0;
    int beats_seen = 0;
    int error_count = 0;
    int cycle_count = 0;

    t_result_beat pending_beats[$];

    // Mirror of the parser state.
    t_payload_seg seg = SEG_CHANNEL;
    logic [7:0]   seg_idx = '0;
    logic [15:0]  chan_word = '0;
    logic [7:0]   ver_list_len = '0;
    logic [7:0]   feat_len = '0;
    logic [7:0]   first_feat = '0;
    logic         bad_payload = 1'b0;
    logic [15:0]  ver_table [pcpp_pkg::MAX_VERSIONS];
    logic [3:0]   ver_count = '0;

    peer_capability_payload_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void absorb_payload_byte(input logic [7:0] b);
        // The first byte of a payload drops whatever the last parse stored.
        if (seg == SEG_CHANNEL && seg_idx == 8'd0) ver_count = '0;
        if (bad_payload) return;
        case (seg)
            SEG_CHANNEL: begin
                chan_word = (seg_idx == 8'd0) ? {8'h00, b} : {chan_word[7:0], b};
                seg_idx++;
                if (seg_idx >= 8'd2) begin
                    seg_idx = '0;
                    seg = SEG_LIST_LEN;
                end
            end
            SEG_LIST_LEN: begin
                ver_list_len = b;
                if (b[0] || b > 8'(2 * pcpp_pkg::MAX_VERSIONS)) begin
                    bad_payload = 1'b1;
                end else begin
                    seg_idx = '0;
                    seg = (b == 8'd0) ? SEG_FEAT_LEN : SEG_VERSIONS;
                end
            end
            SEG_VERSIONS: begin
                if (!seg_idx[0]) ver_table[seg_idx[VT_IDX_W:1]] = {b, 8'h00};
                else ver_table[seg_idx[VT_IDX_W:1]][7:0] = b;
                seg_idx++;
                if (seg_idx >= ver_list_len) begin
                    seg_idx = '0;
                    seg = SEG_FEAT_LEN;
                end
            end
            SEG_FEAT_LEN: begin
                feat_len = b;
                if (b == 8'd0) begin
                    bad_payload = 1'b1;
                end else begin
                    seg_idx = '0;
                    seg = SEG_FEATURES;
                end
            end
            SEG_FEATURES: begin
                if (seg_idx == 8'd0) first_feat = b;
                seg_idx++;
                if (seg_idx >= feat_len) seg = SEG_DONE;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void predict_parser_output(input logic op, input logic [7:0] b,
                                                  input logic eop, input logic [15:0] sel);
        t_result_beat r;
        logic ok;
        r = '0;
        if (op == pcpp_pkg::OP_PAYLOAD) begin
            absorb_payload_byte(b);
            if (eop) begin
                ok = !bad_payload && seg == SEG_DONE;
                ver_count = ok ? ver_list_len[4:1] : 4'd0;
                r.kind = pcpp_pkg::KIND_REPORT;
                r.last = 1'b1;
                if (ok) begin
                    r.status = pcpp_pkg::ST_OK;
                    r.channel = chan_word;
                    r.feature = first_feat;
                    r.count = ver_count;
                end else begin
                    r.status = pcpp_pkg::ST_MALFORMED;
                end
                pending_beats.push_back(r);
                seg = SEG_CHANNEL;
                seg_idx = '0;
                bad_payload = 1'b0;
            end
        end else if (ver_count == 4'd0) begin
            r.kind = pcpp_pkg::KIND_SALT;
            r.status = pcpp_pkg::ST_NO_VERSIONS;
            r.last = 1'b1;
            pending_beats.push_back(r);
        end else begin
            r.kind = pcpp_pkg::KIND_SALT;
            r.status = pcpp_pkg::ST_OK;
            r.count = ver_count;
            for (int i = 0; i < ver_count; i++) begin
                r.salt = ver_table[VT_IDX_W'(i)][15:8];
                pending_beats.push_back(r);
                r.salt = ver_table[VT_IDX_W'(i)][7:0];
                pending_beats.push_back(r);
            end
            r.salt = sel[15:8];
            pending_beats.push_back(r);
            r.salt = sel[7:0];
            r.last = 1'b1;
            pending_beats.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch at result beat %0d: %s", $time, beats_seen, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_result_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat tdata=%h tuser=%b tlast=%b",
                                          o_m_tdata, o_m_tuser, o_m_tlast));
            end else begin
                want = pending_beats.pop_front();
                check_field("result_kind", 16'(o_m_tuser), 16'(want.kind));
                check_field("status", 16'(o_m_tdata[1:0]), 16'(want.status));
                check_field("channel_number", o_m_tdata[17:2], want.channel);
                check_field("feature_bits", 16'(o_m_tdata[25:18]), 16'(want.feature));
                check_field("version_count", 16'(o_m_tdata[29:26]), 16'(want.count));
                check_field("salt_byte", 16'(o_m_tdata[37:30]), 16'(want.salt));
                check_field("tdata padding", 16'(o_m_tdata[39:38]), 16'd0);
                check_field("last_result", 16'(o_m_tlast), 16'(want.last));
            end
            beats_seen++;
        end
    end

    always @(negedge i_clk) begin
        if (sink_stall_pct != 0 && $urandom_range(99, 0) < sink_stall_pct) i_m_tready <= 1'b0;
        else i_m_tready <= 1'b1;
    end

    // Called and returns at a falling edge; valid stays high until the next call
    // idles or the stream drains.
    task automatic send_beat(input logic op, input logic [7:0] data, input logic eop,
                             input logic [15:0] sel);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser = op;
        i_s_tdata = {sel, data};
        i_s_tlast = eop;
        do @(posedge i_clk); while (!o_s_tready);
        predict_parser_output(op, data, eop, sel);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_payload_bytes(input logic [7:0] bytes[$], input int salt_pct);
        for (int i = 0; i < bytes.size(); i++) begin
            send_beat(pcpp_pkg::OP_PAYLOAD, bytes[i], i == bytes.size() - 1, 16'($urandom));
            if (i + 1 < bytes.size() && $urandom_range(99, 0) < salt_pct)
                send_beat(pcpp_pkg::OP_SALT, 8'($urandom), 1'($urandom), 16'($urandom));
        end
    endtask

    task automatic wait_for_drain();
        i_s_tvalid = 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_salt_without_versions();
        send_beat(pcpp_pkg::OP_SALT, 8'h00, 1'b1, 16'h0000);
    endtask

    task automatic test_extreme_payload();
        send_payload_bytes('{8'hFF, 8'hFF, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'hFF}, 0);
        send_beat(pcpp_pkg::OP_SALT, 8'hFF, 1'b0, 16'hFFFF);
    endtask

    task automatic test_short_payloads();
        // A lone byte ends inside the channel number; the salt then finds nothing stored.
        send_payload_bytes('{8'h00}, 0);
        send_beat(pcpp_pkg::OP_SALT, 8'h5A, 1'b1, 16'h8001);
    endtask

    task automatic test_salt_mid_parse();
        send_beat(pcpp_pkg::OP_PAYLOAD, 8'h00, 1'b0, 16'h0000);
        send_beat(pcpp_pkg::OP_SALT, 8'hA5, 1'b0, 16'h5AA5);
        send_payload_bytes('{8'h34, 8'h03, 8'hFF}, 0);
    endtask

    task automatic test_bad_lengths();
        send_payload_bytes('{8'h00, 8'h00, 8'h12}, 0);
        send_payload_bytes('{8'h00, 8'h00, 8'h00, 8'h00}, 0);
        send_beat(pcpp_pkg::OP_SALT, 8'h00, 1'b0, 16'h1234);
    endtask

    task automatic send_random_payload(input bit long_features);
        logic [7:0] bytes[$];
        int nver;
        int flen;
        int pick;
        bytes.push_back(8'($urandom));
        bytes.push_back(8'($urandom));
        pick = $urandom_range(99, 0);
        if (pick < 5) begin
            bytes.push_back(8'(2 * $urandom_range(127, 0) + 1));
        end else if (pick < 9) begin
            bytes.push_back(8'(2 * $urandom_range(127, pcpp_pkg::MAX_VERSIONS + 1)));
        end else begin
            nver = $urandom_range(pcpp_pkg::MAX_VERSIONS, 0);
            bytes.push_back(8'(2 * nver));
            repeat (2 * nver) bytes.push_back(8'($urandom));
        end
        pick = $urandom_range(99, 0);
        if (long_features) flen = 255;
        else if (pick < 6) flen = 0;
        else if (pick < 85) flen = $urandom_range(4, 1);
        else flen = $urandom_range(20, 5);
        bytes.push_back(8'(flen));
        repeat (flen) bytes.push_back(8'($urandom));
        if ($urandom_range(99, 0) < 20)
            repeat ($urandom_range(3, 1)) bytes.push_back(8'($urandom));
        // Truncate somewhere inside the payload now and then.
        if ($urandom_range(99, 0) < 15) begin
            pick = $urandom_range(bytes.size() - 1, 1);
            while (bytes.size() > pick) void'(bytes.pop_back());
        end
        send_payload_bytes(bytes, 4);
        if ($urandom_range(99, 0) < 50)
            send_beat(pcpp_pkg::OP_SALT, 8'($urandom), 1'($urandom), 16'($urandom));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_beats,
                                       input bit with_long_features);
        int start;
        int pick;
        logic [7:0] noise[$];
        send_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        start = beats_sent;
        if (with_long_features) send_random_payload(1'b1);
        while (beats_sent - start < n_beats) begin
            pick = $urandom_range(99, 0);
            if (pick < 75) begin
                send_random_payload(1'b0);
            end else if (pick < 88) begin
                noise.delete();
                repeat ($urandom_range(5, 1)) noise.push_back(8'($urandom));
                send_payload_bytes(noise, 10);
            end else begin
                send_beat(pcpp_pkg::OP_SALT, 8'($urandom), 1'($urandom), 16'($urandom));
            end
        end
        wait_for_drain();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_salt_without_versions();
        test_extreme_payload();
        test_short_payloads();
        test_salt_mid_parse();
        test_bad_lengths();
        wait_for_drain();

        test_random_traffic(0, 0, 300, 1'b1);
        test_random_traffic(88, 0, 50, 1'b0);
        test_random_traffic(0, 88, 50, 1'b0);
        test_random_traffic(10, 10, 50, 1'b0);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
